// ----- src/fpad_pkg.sv -----
// Shared types and constants for the packet framer with padding.
package fpad_pkg;

   localparam int unsigned MAX_PAD_BLOCK_DEF = 16;
   localparam int unsigned PAD_W  = 7;  // holds an effective pad block, at most 31
   localparam int unsigned PADS_W = 6;  // pad run length, below the pad block
   localparam int unsigned POS_W  = 7;  // position within one run of bytes

   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_FILL = 8'h55;

   localparam logic [7:0] PREAMBLE_RESET  = 8'd0;
   localparam logic [4:0] PAD_BLOCK_RESET = 5'd8;

   // Register indexes of the control port.
   localparam logic CSR_PREAMBLE  = 1'b0;
   localparam logic CSR_PAD_BLOCK = 1'b1;

   // Positions in the byte run of one request.
   localparam logic [POS_W-1:0] POS_LEAD = 7'd0;
   localparam logic [POS_W-1:0] POS_PRE0 = 7'd1;
   localparam logic [POS_W-1:0] POS_PRE1 = 7'd2;
   localparam logic [POS_W-1:0] POS_LEN  = 7'd3;
   localparam logic [POS_W-1:0] POS_DATA = 7'd4;
   localparam logic [POS_W-1:0] POS_TRL0 = 7'd5;
   localparam logic [POS_W-1:0] POS_TRL1 = 7'd6;
   localparam logic [POS_W-1:0] POS_TRL2 = 7'd7;

   typedef struct packed {
      logic              has_hdr;
      logic              has_data;
      logic              has_trl;
      logic [7:0]        preamble;
      logic [7:0]        length;
      logic [7:0]        data;
      logic [PADS_W-1:0] pads;
   } plan_type;

   typedef struct packed {
      logic run_busy;
      logic run_done;
   } seq_status_type;

endpackage

// ----- src/fpad_plan.sv -----
// Frame state and per-request planning of the byte run.
module fpad_plan #(
   parameter int unsigned MAX_PAD_BLOCK = fpad_pkg::MAX_PAD_BLOCK_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         payload_byte,
   input  logic [7:0]         packet_length,
   input  logic               last_item,
   input  logic [7:0]         preamble_byte,
   input  logic [4:0]         pad_block,
   output fpad_pkg::plan_type plan
);
   import fpad_pkg::*;

   localparam int unsigned PH_W = $clog2(MAX_PAD_BLOCK + 1);
   localparam logic [PAD_W-1:0] MAX_BLK = PAD_W'(MAX_PAD_BLOCK);

   logic            in_frame_ff, in_frame_in;
   logic [7:0]      count_ff, count_in;
   logic [7:0]      flen_ff, flen_in;
   logic [PH_W-1:0] phase_ff, phase_in;

   logic [PAD_W-1:0] eff_blk;
   logic [PAD_W-1:0] phase_inc;
   logic [PAD_W-1:0] trl_phase;
   logic [PH_W-1:0]  phase_base;
   logic [PH_W-1:0]  phase_new;
   logic [7:0]       count_new;
   logic [7:0]       flen_use;
   logic             start, empty, frame_end;

   always_comb begin
      eff_blk = {2'b00, pad_block};
      if (eff_blk == '0) begin
         eff_blk = PAD_W'(1);
      end else if (eff_blk > MAX_BLK) begin
         eff_blk = MAX_BLK;
      end

      start      = !in_frame_ff;
      empty      = start && (packet_length == 8'd0);
      phase_base = start ? '0 : phase_ff;
      count_new  = (start ? 8'd0 : count_ff) + 8'd1;
      flen_use   = start ? packet_length : flen_ff;

      // Wrap the phase at the pad block; an out-of-range phase wraps too.
      phase_inc = PAD_W'(phase_base) + PAD_W'(1);
      phase_new = (phase_inc >= eff_blk) ? '0 : PH_W'(phase_inc);

      frame_end = empty || last_item || (count_new == flen_use);
      trl_phase = empty ? '0 : PAD_W'(phase_new);

      plan.has_hdr  = start;
      plan.has_data = !empty;
      plan.has_trl  = frame_end;
      plan.preamble = preamble_byte;
      plan.length   = packet_length;
      plan.data     = payload_byte;
      plan.pads     = '0;
      if (trl_phase != '0 && trl_phase < eff_blk) begin
         plan.pads = PADS_W'(eff_blk - trl_phase);
      end

      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      flen_in     = flen_ff;
      phase_in    = phase_ff;
      if (accept) begin
         in_frame_in = !frame_end;
         count_in    = empty ? 8'd0 : count_new;
         flen_in     = flen_use;
         phase_in    = empty ? '0 : phase_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         flen_ff     <= '0;
         phase_ff    <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         flen_ff     <= flen_in;
         phase_ff    <= phase_in;
      end
   end

endmodule

// ----- src/fpad_seq.sv -----
// Run register, byte sequencer and result register.
module fpad_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  fpad_pkg::plan_type       plan_in,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last_of_run,
   output logic                     rsp_end_of_frame,
   output fpad_pkg::seq_status_type status
);
   import fpad_pkg::*;

   logic             run_valid_ff, run_valid_in;
   plan_type         run_ff, run_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             eof_ff, eof_in;

   logic             out_free, fire, at_end;
   logic [POS_W-1:0] end_pos, next_pos;
   logic [7:0]       cur_byte;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      fire     = run_valid_ff && out_free;
      end_pos  = run_ff.has_trl ? (POS_TRL2 + POS_W'(run_ff.pads)) : POS_DATA;
      at_end   = (pos_ff == end_pos);
      // Skip the data slot for an empty packet.
      next_pos = (pos_ff == POS_LEN && !run_ff.has_data) ? POS_TRL0 : pos_ff + POS_W'(1);

      case (pos_ff)
         POS_LEAD: cur_byte = BYTE_ZERO;
         POS_PRE0: cur_byte = run_ff.preamble;
         POS_PRE1: cur_byte = run_ff.preamble;
         POS_LEN:  cur_byte = run_ff.length;
         POS_DATA: cur_byte = run_ff.data;
         POS_TRL0: cur_byte = BYTE_ZERO;
         POS_TRL1: cur_byte = BYTE_ZERO;
         default:  cur_byte = BYTE_FILL;
      endcase

      req_stall = run_valid_ff && !(fire && at_end);

      run_valid_in = run_valid_ff;
      run_in       = run_ff;
      pos_in       = pos_ff;
      if (load) begin
         run_valid_in = 1'b1;
         run_in       = plan_in;
         pos_in       = plan_in.has_hdr ? POS_LEAD : POS_DATA;
      end else if (fire && at_end) begin
         run_valid_in = 1'b0;
      end else if (fire) begin
         pos_in = next_pos;
      end

      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      eof_in       = eof_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         byte_in      = cur_byte;
         last_in      = at_end;
         eof_in       = at_end && run_ff.has_trl;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      status.run_busy = run_valid_ff;
      status.run_done = fire && at_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_valid_ff <= run_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff  <= run_in;
      pos_ff  <= pos_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      eof_ff  <= eof_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_last_of_run  = last_ff;
   assign rsp_end_of_frame = eof_ff;

endmodule

// ----- src/packet_framer_with_padding.sv -----
// An accepted request is registered in the run register; its first byte then goes
// through the result register. Throughput: one result byte per cycle unless the
// output stalls; an N-byte request stalls the request port until its last byte, so
// payload requests in a frame go at one per cycle; the byte sequencer sets that rate.
// Reset (synchronous): no frame open, nothing queued, preamble 0, pad block 8.
module packet_framer_with_padding #(
   parameter int unsigned MAX_PAD_BLOCK = fpad_pkg::MAX_PAD_BLOCK_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_payload_byte,
   input  logic [7:0] req_packet_length,
   input  logic       req_last_item,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   output logic       rsp_end_of_frame,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);
   import fpad_pkg::*;

   logic [7:0]     preamble_ff, preamble_in;
   logic [4:0]     pad_block_ff, pad_block_in;
   logic           accept;
   plan_type       plan;
   seq_status_type status;

   always_comb begin
      csr_ready    = 1'b1;
      preamble_in  = preamble_ff;
      pad_block_in = pad_block_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PREAMBLE:  preamble_in  = csr_data;
            CSR_PAD_BLOCK: pad_block_in = csr_data[4:0];
            default:       preamble_in  = preamble_ff;
         endcase
      end
      accept = req_valid && !req_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff  <= PREAMBLE_RESET;
         pad_block_ff <= PAD_BLOCK_RESET;
      end else begin
         preamble_ff  <= preamble_in;
         pad_block_ff <= pad_block_in;
      end
   end

   fpad_plan #(
      .MAX_PAD_BLOCK(MAX_PAD_BLOCK)
   ) u_plan (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .payload_byte  (req_payload_byte),
      .packet_length (req_packet_length),
      .last_item     (req_last_item),
      .preamble_byte (preamble_ff),
      .pad_block     (pad_block_ff),
      .plan          (plan)
   );

   fpad_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .load             (accept),
      .plan_in          (plan),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_frame (rsp_end_of_frame),
      .status           (status)
   );

   // A frame always ends on the last byte of a request's run.
   a_eof_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> rsp_last_of_run)
      else $error("end of frame before end of run");

   // Stall the request side only while a run is in progress.
   a_stall_needs_run: assert property (@(posedge clock) disable iff (reset)
      !status.run_busy |-> !req_stall)
      else $error("request stalled with no run in progress");

   // Finishing a run always leaves a result holding the last-of-run flag.
   a_done_marks_last: assert property (@(posedge clock) disable iff (reset)
      status.run_done |=> rsp_valid && rsp_last_of_run)
      else $error("run finished without a last-of-run result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
